@@ sv/vrrm_pkg.sv @@
// ----------------------------------------------------------------------------
// vrrm_pkg
// Shared types, constants and helpers of the variable record ring manager.
// ----------------------------------------------------------------------------
package vrrm_pkg;

   // Build-time sizing
   localparam int RING_BYTES   = 65536;
   localparam int MAX_RECORDS  = 4096;
   localparam int HEADER_BYTES = 16;
   localparam int ALIGN_BYTES  = 8;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int TOPIC_W  = 12;
   localparam int DATA_W   = 16;
   localparam int OFF_W    = 16;
   localparam int RING_W   = 17;
   localparam int MAXREC_W = 13;
   localparam int CSR_W    = 17;
   localparam int CSR_IDX_W = 1;

   // Internal widths
   localparam int PTR_W    = $clog2(MAX_RECORDS);
   localparam int ENTRY_W  = TOPIC_W + DATA_W;
   localparam int SUM_W    = 20;
   localparam int ALIGN_SH = $clog2(ALIGN_BYTES);

   // Ring size in effect never exceeds the offset range or the build size
   localparam int RING_CAP = (RING_BYTES < (1 << OFF_W)) ? RING_BYTES : (1 << OFF_W);

   // Reset values of the registers
   localparam logic [RING_W-1:0]   RING_SIZE_RST  = RING_W'(65536);
   localparam logic [MAXREC_W-1:0] MAX_RECORD_RST = MAXREC_W'(4096);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_PEEK  = 2'd2,
      CMD_RESET = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 3'd0,
      ST_EMPTY  = 3'd1,
      ST_BADLEN = 3'd2,
      ST_TOOBIG = 3'd3,
      ST_FULL   = 3'd4,
      ST_ERROR  = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RING_SIZE  = 1'd0,
      CSR_MAX_RECORD = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [TOPIC_W-1:0] topic_bytes;
      logic [DATA_W-1:0]  data_bytes;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFF_W-1:0]    record_offset;
      logic [TOPIC_W-1:0]  head_topic_bytes;
      logic [DATA_W-1:0]   head_data_bytes;
      logic                error_flag;
   } rsp_type;

   // Header + topic + data, rounded up to the alignment
   function automatic logic [SUM_W-1:0] aligned_size(logic [TOPIC_W-1:0] topic,
                                                     logic [DATA_W-1:0]  data);
      logic [SUM_W-1:0] raw;
      raw = SUM_W'(HEADER_BYTES) + SUM_W'(topic) + SUM_W'(data) + SUM_W'(ALIGN_BYTES - 1);
      return (raw >> ALIGN_SH) << ALIGN_SH;
   endfunction

   // Length FIFO pointer increment with wrap
   function automatic logic [PTR_W-1:0] fifo_next(logic [PTR_W-1:0] p);
      return (p == PTR_W'(MAX_RECORDS - 1)) ? '0 : p + PTR_W'(1);
   endfunction

endpackage

@@ sv/variable_record_ring_manager_top.sv @@
// ----------------------------------------------------------------------------
// variable_record_ring_manager_top
// A command's result word is registered when the command is accepted.
// Throughput: one command per cycle while the result side is not stalled; the
// length FIFO head is prefetched from memory into a register for pop and peek.
// Reset clears offsets, FIFO pointers, error and output valid at once; the
// length memory is not cleared (entries are read only after being written).
// ----------------------------------------------------------------------------
module variable_record_ring_manager_top (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  vrrm_pkg::req_type                   req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output vrrm_pkg::rsp_type                   rsp_data,
   // register write port
   input  logic                                csr_we,
   input  logic [vrrm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vrrm_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int SUM_W   = vrrm_pkg::SUM_W;
   localparam int PTR_W   = vrrm_pkg::PTR_W;
   localparam int OFF_W   = vrrm_pkg::OFF_W;
   localparam int ENTRY_W = vrrm_pkg::ENTRY_W;
   localparam int TOPIC_W = vrrm_pkg::TOPIC_W;
   localparam int DATA_W  = vrrm_pkg::DATA_W;

   // Registers
   logic [vrrm_pkg::RING_W-1:0]   ring_size_ff;
   logic [vrrm_pkg::MAXREC_W-1:0] max_rec_ff;
   logic [OFF_W-1:0]              rd_off_ff,  rd_off_in;
   logic [OFF_W-1:0]              wr_off_ff,  wr_off_in;
   logic                          sticky_ff,  sticky_in;
   logic [PTR_W-1:0]              head_ff,    head_in;
   logic [PTR_W-1:0]              tail_ff,    tail_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   vrrm_pkg::rsp_type             rsp_data_ff,  rsp_data_in;

   // Length memory and head prefetch
   logic [ENTRY_W-1:0]            len_mem [vrrm_pkg::MAX_RECORDS];
   logic [ENTRY_W-1:0]            mem_q_ff;
   logic [ENTRY_W-1:0]            byp_ff;
   logic                          byp_sel_ff;
   logic                          mem_we;
   logic [ENTRY_W-1:0]            mem_wdata;
   logic [PTR_W-1:0]              rd_addr;

   // Datapath
   logic                          req_accept;
   logic [SUM_W-1:0]              ring;
   logic [SUM_W-1:0]              max_rec;
   logic [SUM_W-1:0]              need;
   logic [SUM_W-1:0]              room;
   logic [SUM_W-1:0]              nend;
   logic                          fifo_full;
   logic                          fifo_empty;
   logic [ENTRY_W-1:0]            head_entry;
   logic [TOPIC_W-1:0]            head_topic;
   logic [DATA_W-1:0]             head_data;
   logic [SUM_W-1:0]              nb;

   assign req_accept = req_valid && req_ready;
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Ring size in effect and wrap margin
   assign ring = (ring_size_ff > vrrm_pkg::RING_W'(vrrm_pkg::RING_CAP))
               ? SUM_W'(vrrm_pkg::RING_CAP) : SUM_W'(ring_size_ff);
   assign max_rec = SUM_W'(max_rec_ff);

   // Push arithmetic
   assign need = vrrm_pkg::aligned_size(req_data.topic_bytes, req_data.data_bytes);
   always_comb begin
      if (rd_off_ff > wr_off_ff) begin
         room = SUM_W'(rd_off_ff) - SUM_W'(wr_off_ff) - SUM_W'(1);
      end else if (SUM_W'(wr_off_ff) >= ring) begin
         room = '0;
      end else begin
         room = ring - SUM_W'(wr_off_ff);
      end
   end
   assign nend      = SUM_W'(wr_off_ff) + need;
   assign fifo_full = (vrrm_pkg::fifo_next(tail_ff) == head_ff);
   assign fifo_empty = (rd_off_ff == wr_off_ff) || (head_ff == tail_ff);

   // Head entry: memory output unless it was written in the cycle of its read
   assign head_entry = byp_sel_ff ? byp_ff : mem_q_ff;
   assign head_topic = head_entry[ENTRY_W-1:DATA_W];
   assign head_data  = head_entry[DATA_W-1:0];
   assign nb = SUM_W'(rd_off_ff) + vrrm_pkg::aligned_size(head_topic, head_data);

   // Command evaluation
   always_comb begin
      rd_off_in   = rd_off_ff;
      wr_off_in   = wr_off_ff;
      sticky_in   = sticky_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      mem_we      = 1'b0;
      mem_wdata   = {req_data.topic_bytes, req_data.data_bytes};
      rsp_data_in = '0;
      rsp_data_in.status = vrrm_pkg::ST_OK;
      if (req_accept) begin
         case (req_data.cmd)
            vrrm_pkg::CMD_PUSH: begin
               if (req_data.topic_bytes == '0 || req_data.data_bytes == '0) begin
                  rsp_data_in.status = vrrm_pkg::ST_BADLEN;
               end else if (need > max_rec) begin
                  rsp_data_in.status = vrrm_pkg::ST_TOOBIG;
               end else if (sticky_ff) begin
                  rsp_data_in.status = vrrm_pkg::ST_ERROR;
               end else if (room < need || fifo_full ||
                            ((nend + max_rec > ring) && rd_off_ff == '0)) begin
                  rsp_data_in.status = vrrm_pkg::ST_FULL;
                  sticky_in = 1'b1;
               end else begin
                  rsp_data_in.record_offset = wr_off_ff;
                  mem_we    = 1'b1;
                  tail_in   = vrrm_pkg::fifo_next(tail_ff);
                  wr_off_in = (nend + max_rec > ring) ? '0 : nend[OFF_W-1:0];
               end
            end
            vrrm_pkg::CMD_POP,
            vrrm_pkg::CMD_PEEK: begin
               if (sticky_ff) begin
                  rsp_data_in.status = vrrm_pkg::ST_ERROR;
               end else if (fifo_empty) begin
                  rsp_data_in.status = vrrm_pkg::ST_EMPTY;
               end else if (req_data.cmd == vrrm_pkg::CMD_PEEK) begin
                  rsp_data_in.record_offset    = rd_off_ff;
                  rsp_data_in.head_topic_bytes = head_topic;
                  rsp_data_in.head_data_bytes  = head_data;
               end else begin
                  rd_off_in = (nb + max_rec > ring) ? '0 : nb[OFF_W-1:0];
                  head_in   = vrrm_pkg::fifo_next(head_ff);
               end
            end
            vrrm_pkg::CMD_RESET: begin
               rd_off_in = '0;
               wr_off_in = '0;
               sticky_in = 1'b0;
               head_in   = '0;
               tail_in   = '0;
            end
            default: begin
               rsp_data_in.status = vrrm_pkg::ST_OK;
            end
         endcase
      end
      rsp_data_in.error_flag = sticky_in;
   end

   // Output word handshake
   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_off_ff    <= '0;
         wr_off_ff    <= '0;
         sticky_ff    <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_off_ff    <= rd_off_in;
         wr_off_ff    <= wr_off_in;
         sticky_ff    <= sticky_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= vrrm_pkg::RING_SIZE_RST;
         max_rec_ff   <= vrrm_pkg::MAX_RECORD_RST;
      end else if (csr_we) begin
         case (csr_index)
            vrrm_pkg::CSR_RING_SIZE:  ring_size_ff <= csr_wdata[vrrm_pkg::RING_W-1:0];
            vrrm_pkg::CSR_MAX_RECORD: max_rec_ff   <= csr_wdata[vrrm_pkg::MAXREC_W-1:0];
            default: ;
         endcase
      end
   end

   // Length memory: write at tail, read the next head every cycle
   assign rd_addr = reset ? '0 : head_in;

   always_ff @(posedge clock) begin
      if (mem_we && !reset) begin
         len_mem[tail_ff] <= mem_wdata;
      end
      mem_q_ff   <= len_mem[rd_addr];
      byp_ff     <= mem_wdata;
      byp_sel_ff <= mem_we && !reset && (tail_ff == rd_addr);
   end

endmodule

@@ verif/variable_record_ring_manager_top_test.sv @@
// ----------------------------------------------------------------------------
// variable_record_ring_manager_top_test
// Drives push, pop, peek and reset commands into the ring manager under
// several ring and record size settings, predicts every result word from a
// local model of the offsets, sticky error and length FIFO, and compares each
// returned word with the oldest prediction. Both channels idle at random, and
// the result side holds off long enough at one point to back up the input.
// ----------------------------------------------------------------------------
module variable_record_ring_manager_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF   = 6;
   localparam int RESET_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int IDLE_PCT     = 38;
   localparam int REPORT_LIMIT = 10;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   vrrm_pkg::req_type              req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   vrrm_pkg::rsp_type              rsp_data;
   logic                           csr_we    = 1'b0;
   logic [vrrm_pkg::CSR_IDX_W-1:0] csr_index = vrrm_pkg::CSR_RING_SIZE;
   logic [vrrm_pkg::CSR_W-1:0]     csr_wdata = '0;

   // Local copy of the block's state and settings
   logic [vrrm_pkg::RING_W-1:0]    cfg_ring_bytes = vrrm_pkg::RING_SIZE_RST;
   logic [vrrm_pkg::MAXREC_W-1:0]  cfg_max_record = vrrm_pkg::MAX_RECORD_RST;
   int unsigned                    exp_read_off   = 0;
   int unsigned                    exp_write_off  = 0;
   bit                             exp_error      = 1'b0;
   logic [vrrm_pkg::ENTRY_W-1:0]   len_store [vrrm_pkg::MAX_RECORDS];
   int unsigned                    store_head     = 0;
   int unsigned                    store_tail     = 0;

   vrrm_pkg::rsp_type              pending_responses [$];
   int unsigned                    mismatch_count = 0;
   int unsigned                    cycle_count    = 0;
   bit                             quiet_mode     = 1'b0;
   int unsigned                    stall_request  = 0;

   variable_record_ring_manager_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #CLOCK_HALF clock = ~clock;

   // Bytes a record takes in the ring: header, topic, data, rounded up
   function automatic int unsigned record_bytes(input int unsigned topic,
                                                input int unsigned data);
      return ((vrrm_pkg::HEADER_BYTES + topic + data + vrrm_pkg::ALIGN_BYTES - 1)
              / vrrm_pkg::ALIGN_BYTES) * vrrm_pkg::ALIGN_BYTES;
   endfunction

   function automatic int unsigned next_slot(input int unsigned p);
      return (p + 1 >= vrrm_pkg::MAX_RECORDS) ? 0 : p + 1;
   endfunction

   // Applies one command to the local state and returns the word it answers
   function automatic vrrm_pkg::rsp_type next_response(input vrrm_pkg::req_type w);
      vrrm_pkg::rsp_type            r;
      int unsigned                  ring, need, room, nend, nb;
      logic [vrrm_pkg::ENTRY_W-1:0] e;
      bit                           no_room;
      r = '0;
      ring = (cfg_ring_bytes > vrrm_pkg::RING_CAP) ? vrrm_pkg::RING_CAP : cfg_ring_bytes;
      case (w.cmd)
         vrrm_pkg::CMD_RESET: begin
            exp_read_off  = 0;
            exp_write_off = 0;
            exp_error     = 1'b0;
            store_head    = 0;
            store_tail    = 0;
         end
         vrrm_pkg::CMD_PUSH: begin
            need = record_bytes(w.topic_bytes, w.data_bytes);
            if (w.topic_bytes == 0 || w.data_bytes == 0) begin
               r.status = vrrm_pkg::ST_BADLEN;
            end else if (need > cfg_max_record) begin
               r.status = vrrm_pkg::ST_TOOBIG;
            end else if (exp_error) begin
               r.status = vrrm_pkg::ST_ERROR;
            end else begin
               no_room = 1'b0;
               // one byte stays free when the writer is behind the reader
               if (exp_read_off > exp_write_off)
                  room = exp_read_off - exp_write_off - 1;
               else
                  room = (exp_write_off >= ring) ? 0 : ring - exp_write_off;
               nend = exp_write_off + need;
               if (room < need) begin
                  no_room = 1'b1;
               end else if (nend + cfg_max_record > ring) begin
                  if (exp_read_off == 0) no_room = 1'b1;
                  else nend = 0;
               end
               if (next_slot(store_tail) == store_head) no_room = 1'b1;
               if (no_room) begin
                  r.status  = vrrm_pkg::ST_FULL;
                  exp_error = 1'b1;
               end else begin
                  r.record_offset       = vrrm_pkg::OFF_W'(exp_write_off);
                  len_store[store_tail] = {w.topic_bytes, w.data_bytes};
                  store_tail            = next_slot(store_tail);
                  exp_write_off         = nend & 16'hFFFF;
               end
            end
         end
         default: begin
            if (exp_error) begin
               r.status = vrrm_pkg::ST_ERROR;
            end else if (exp_read_off == exp_write_off || store_head == store_tail) begin
               r.status = vrrm_pkg::ST_EMPTY;
            end else begin
               e = len_store[store_head];
               if (w.cmd == vrrm_pkg::CMD_PEEK) begin
                  r.record_offset    = vrrm_pkg::OFF_W'(exp_read_off);
                  r.head_topic_bytes = e[vrrm_pkg::DATA_W +: vrrm_pkg::TOPIC_W];
                  r.head_data_bytes  = e[0 +: vrrm_pkg::DATA_W];
               end else begin
                  nb = exp_read_off + record_bytes(e[vrrm_pkg::DATA_W +: vrrm_pkg::TOPIC_W],
                                                   e[0 +: vrrm_pkg::DATA_W]);
                  if (nb + cfg_max_record > ring) nb = 0;
                  exp_read_off = nb & 16'hFFFF;
                  store_head   = next_slot(store_head);
               end
            end
         end
      endcase
      r.error_flag = exp_error;
      return r;
   endfunction

   // Push with lengths shaped around the current record limit
   function automatic vrrm_pkg::req_type random_push();
      vrrm_pkg::req_type w;
      int unsigned       budget, total, pick, t;
      budget = (cfg_max_record > vrrm_pkg::HEADER_BYTES + 2)
             ? cfg_max_record - vrrm_pkg::HEADER_BYTES : 2;
      pick = $urandom_range(99);
      w.cmd         = vrrm_pkg::CMD_PUSH;
      w.topic_bytes = vrrm_pkg::TOPIC_W'($urandom);
      w.data_bytes  = vrrm_pkg::DATA_W'($urandom);
      if (pick < 8) begin
         // zero lengths
         case ($urandom_range(2))
            0: w.topic_bytes = '0;
            1: w.data_bytes = '0;
            default: begin
               w.topic_bytes = '0;
               w.data_bytes  = '0;
            end
         endcase
      end else if (pick >= 16) begin
         // near the limit, or small so the ring holds many records
         if (pick < 40)
            total = $urandom_range(budget, (budget > 17) ? budget - 15 : 2);
         else
            total = $urandom_range((budget < 200) ? budget : 200, 2);
         t = $urandom_range((total - 1 < 4095) ? total - 1 : 4095, 1);
         w.topic_bytes = vrrm_pkg::TOPIC_W'(t);
         w.data_bytes  = vrrm_pkg::DATA_W'(total - t);
      end
      return w;
   endfunction

   // Command mix; a stuck queue gets cleared fairly soon
   function automatic vrrm_pkg::req_type random_command(input int unsigned push_pct);
      vrrm_pkg::req_type w;
      int unsigned       pick;
      pick = $urandom_range(99);
      w.cmd         = vrrm_pkg::CMD_PEEK;
      w.topic_bytes = vrrm_pkg::TOPIC_W'($urandom);
      w.data_bytes  = vrrm_pkg::DATA_W'($urandom);
      if (exp_error && pick < 40)
         w.cmd = vrrm_pkg::CMD_RESET;
      else if (pick < 2)
         w.cmd = vrrm_pkg::CMD_RESET;
      else if (pick < 2 + push_pct)
         w = random_push();
      else if (pick < 2 + push_pct + (98 - push_pct) * 3 / 5)
         w.cmd = vrrm_pkg::CMD_POP;
      return w;
   endfunction

   function automatic vrrm_pkg::req_type make_word(input vrrm_pkg::cmd_type cmd,
                                                   input int unsigned topic,
                                                   input int unsigned data);
      vrrm_pkg::req_type w;
      w.cmd         = cmd;
      w.topic_bytes = vrrm_pkg::TOPIC_W'(topic);
      w.data_bytes  = vrrm_pkg::DATA_W'(data);
      return w;
   endfunction

   // Offers one command word; called and returns at a falling edge
   task automatic send_word(input vrrm_pkg::req_type w);
      while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_responses.push_back(next_response(w));
      @(negedge clock);
   endtask

   task automatic send_cmd(input vrrm_pkg::cmd_type cmd, input int unsigned topic,
                           input int unsigned data);
      send_word(make_word(cmd, topic, data));
   endtask

   // Block drained: nothing offered, nothing outstanding
   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_responses.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_register(input vrrm_pkg::csr_index_type idx,
                                 input int unsigned value);
      wait_idle();
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = vrrm_pkg::CSR_W'(value);
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == vrrm_pkg::CSR_RING_SIZE) cfg_ring_bytes = vrrm_pkg::RING_W'(value);
      else cfg_max_record = vrrm_pkg::MAXREC_W'(value);
   endtask

   task automatic run_traffic(input int unsigned ring_bytes, input int unsigned max_bytes,
                              input int unsigned count);
      int unsigned push_pct;
      write_register(vrrm_pkg::CSR_RING_SIZE, ring_bytes);
      write_register(vrrm_pkg::CSR_MAX_RECORD, max_bytes);
      push_pct = 50;
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 50 == 0) push_pct = 35 + 15 * $urandom_range(2);
         send_word(random_command(push_pct));
      end
   endtask

   // Empty queue, rejected lengths and the size limit at reset settings
   task automatic check_lengths_and_empty();
      send_cmd(vrrm_pkg::CMD_POP, 0, 0);
      send_cmd(vrrm_pkg::CMD_PEEK, 4095, 65535);
      send_cmd(vrrm_pkg::CMD_PUSH, 0, 7);
      send_cmd(vrrm_pkg::CMD_PUSH, 9, 0);
      send_cmd(vrrm_pkg::CMD_PUSH, 4095, 65535);
      send_cmd(vrrm_pkg::CMD_PUSH, 1, 1);
      send_cmd(vrrm_pkg::CMD_PUSH, 80, 4000);   // exactly the limit
      send_cmd(vrrm_pkg::CMD_PUSH, 80, 4001);   // one alignment step over
      send_cmd(vrrm_pkg::CMD_PEEK, 0, 0);
      send_cmd(vrrm_pkg::CMD_POP, 0, 0);
      send_cmd(vrrm_pkg::CMD_PEEK, 0, 0);
      send_cmd(vrrm_pkg::CMD_POP, 0, 0);
      send_cmd(vrrm_pkg::CMD_POP, 0, 0);
   endtask

   // Small ring: fill to the sticky error, check rejects, then wrap the writer
   task automatic check_fill_and_wrap();
      write_register(vrrm_pkg::CSR_RING_SIZE, 1024);
      write_register(vrrm_pkg::CSR_MAX_RECORD, 256);
      send_cmd(vrrm_pkg::CMD_RESET, 0, 0);
      repeat (4) send_cmd(vrrm_pkg::CMD_PUSH, 100, 140);
      send_cmd(vrrm_pkg::CMD_POP, 0, 0);
      send_cmd(vrrm_pkg::CMD_PEEK, 0, 0);
      send_cmd(vrrm_pkg::CMD_PUSH, 0, 5);       // length check ranks above the error
      send_cmd(vrrm_pkg::CMD_PUSH, 4095, 65535);
      send_cmd(vrrm_pkg::CMD_PUSH, 100, 140);
      send_cmd(vrrm_pkg::CMD_RESET, 0, 0);
      repeat (3) send_cmd(vrrm_pkg::CMD_PUSH, 100, 140);
      send_cmd(vrrm_pkg::CMD_POP, 0, 0);
      send_cmd(vrrm_pkg::CMD_PUSH, 100, 140);   // writer wraps to the start
      send_cmd(vrrm_pkg::CMD_PUSH, 100, 132);   // fits below the reserved byte
      send_cmd(vrrm_pkg::CMD_PUSH, 1, 1);       // behind reader, no room
      send_cmd(vrrm_pkg::CMD_RESET, 0, 0);
   endtask

   task automatic check_large_ring();
      run_traffic(65536, 4096, 400);
   endtask

   task automatic check_small_ring();
      run_traffic(1024, 32, 400);
   endtask

   // Long stretch with no idling on either side
   task automatic check_back_to_back();
      wait_idle();
      quiet_mode = 1'b1;
      run_traffic(2048, 256, 300);
      quiet_mode = 1'b0;
   endtask

   // Margin larger than the ring: every push either wraps or fails
   task automatic check_oversized_margin();
      run_traffic(1024, 4096, 100);
   endtask

   // Result side held off while commands keep coming
   task automatic check_backpressure();
      wait_idle();
      quiet_mode    = 1'b1;
      stall_request = 250;
      repeat (60) send_word(random_command(50));
      quiet_mode = 1'b0;
   endtask

   task automatic check_random_settings();
      repeat (3) run_traffic($urandom_range(65536, 1024), $urandom_range(4096, 32), 200);
   endtask

   // Result side ready pattern, with the requested hold-off
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = quiet_mode || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      vrrm_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: result word %h with no command pending", $time, rsp_data);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.record_offset !== want.record_offset ||
                rsp_data.head_topic_bytes !== want.head_topic_bytes ||
                rsp_data.head_data_bytes !== want.head_data_bytes ||
                rsp_data.error_flag !== want.error_flag) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"%0t: expected status %0d offset %0d topic %0d data %0d err %0d,",
                            " got status %0d offset %0d topic %0d data %0d err %0d"},
                           $time, want.status, want.record_offset, want.head_topic_bytes,
                           want.head_data_bytes, want.error_flag, rsp_data.status,
                           rsp_data.record_offset, rsp_data.head_topic_bytes,
                           rsp_data.head_data_bytes, rsp_data.error_flag);
            end
         end
      end
   end

   // Run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // Test sequence
   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;
      check_lengths_and_empty();
      check_fill_and_wrap();
      check_large_ring();
      check_small_ring();
      check_back_to_back();
      check_oversized_margin();
      check_backpressure();
      check_random_settings();
      wait_idle();
      repeat (2) @(negedge clock);
      if (mismatch_count == 0 && pending_responses.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
